### rtl/was_pkg.sv
// ----------------------------------------------------------------------------
// was_pkg
// Shared types and defaults for the windowed axis statistics block.
// ----------------------------------------------------------------------------
package was_pkg;

  localparam int unsigned DefMaxWindow  = 1024;
  localparam int unsigned DefSampleBits = 16;
  localparam int unsigned LenBits       = 11;
  localparam int unsigned OutBits       = 16;
  localparam int unsigned VarBits       = 31;
  localparam logic [LenBits-1:0] WinReset = LenBits'(1000);

  // per-lane control from the window counter
  typedef struct packed {
    logic acc;    // active beat, accumulate
    logic clr;    // inactive beat, restart window
    logic close;  // beat that ends the window
    logic take;   // result moved to the output register
  } was_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } was_stat_t;

endpackage

### rtl/was_div.sv
// ----------------------------------------------------------------------------
// was_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module was_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CNW = $clog2(NW + 1);

  logic [NW-1:0]  quo_q;
  logic [DW-1:0]  rem_q;
  logic [CNW-1:0] cnt_q;
  logic           busy_q, done_q;
  logic [DW:0]    trial;
  logic           fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, den_i}) : DW'(trial);
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### rtl/was_lane.sv
// ----------------------------------------------------------------------------
// was_lane
// One axis: running sum, sum of squares, min and max, plus the window-end
// sequencer for mean and variance.
// ----------------------------------------------------------------------------
module was_lane import was_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DefSampleBits,
  parameter int unsigned CW          = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  was_ctrl_t              ctrl_i,
  input  logic [CW-1:0]          k_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output was_stat_t              stat_o,
  output logic [OutBits-1:0]     mean_o,
  output logic [VarBits-1:0]     var_o,
  output logic [OutBits-1:0]     max_o,
  output logic [OutBits-1:0]     min_o
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned SW  = SB + CW;
  localparam int unsigned QW  = 2 * SB + CW;
  localparam int unsigned NW  = QW + CW;
  localparam int unsigned DW  = 2 * CW;
  localparam int unsigned XW  = (NW > VarBits) ? NW : VarBits + 1;
  localparam int unsigned MCW = $clog2(CW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [SB-1:0] SMin = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] SMax = {1'b0, {(SB-1){1'b1}}};

  // accumulators
  logic signed [SW-1:0] sum_q, sum_d;
  logic [QW-1:0]        sq_q, sq_d;
  logic [SB-1:0]        max_q, max_d, min_q, min_d;
  logic signed [SB-1:0] sx;
  logic signed [2*SB-1:0] sxx;

  assign sx    = $signed(sample_i);
  assign sxx   = sx * sx;
  assign sum_d = sum_q + SW'(sx);
  assign sq_d  = sq_q + QW'($unsigned(sxx));
  assign max_d = (sx > $signed(max_q)) ? sample_i : max_q;
  assign min_d = (sx < $signed(min_q)) ? sample_i : min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sq_q  <= '0;
      max_q <= SMin;
      min_q <= SMax;
    end else if (ctrl_i.clr || ctrl_i.close) begin
      sum_q <= '0;
      sq_q  <= '0;
      max_q <= SMin;
      min_q <= SMax;
    end else if (ctrl_i.acc) begin
      sum_q <= sum_d;
      sq_q  <= sq_d;
      max_q <= max_d;
      min_q <= min_d;
    end
  end

  // window-end sequencer
  logic [2:0]           st_q, st_d;
  logic signed [SW-1:0] f_sum_q;
  logic [QW-1:0]        f_sq_q;
  logic [SB-1:0]        f_max_q, f_min_q;
  logic [CW-1:0]        f_k_q, mk_q;
  logic [SW-1:0]        mag_q;
  logic [NW-1:0]        magsq_q, prod_q, mcand_q, num_q;
  logic [DW-1:0]        den_q;
  logic [MCW-1:0]       mcnt_q;
  logic [OutBits-1:0]   mean_q;
  logic [VarBits-1:0]   var_q;
  logic                 div_go;
  logic                 vdone, mdone;
  logic [NW-1:0]        vquo;
  logic [DW-1:0]        vrem;
  logic [SW-1:0]        mquo;
  logic [CW-1:0]        mrem;
  logic signed [SW-1:0] mean_v;
  logic [SB-1:0]        mean_t;
  logic [XW-1:0]        vq_x;

  assign div_go = (st_q == S_DIV);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE:  if (ctrl_i.close) st_d = S_PREP;
      S_PREP:  st_d = S_MUL;
      S_MUL:   if (mcnt_q == MCW'(1)) st_d = S_SUB;
      S_SUB:   st_d = S_DIV;
      S_DIV:   st_d = S_WAIT;
      S_WAIT:  if (vdone && mdone) st_d = S_DONE;
      S_DONE:  if (ctrl_i.take) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // floor division for the mean: round away from zero when negative
  assign mean_v = f_sum_q[SW-1] ? -$signed(mquo + SW'(mrem != '0)) : $signed(mquo);
  assign mean_t = SB'(mean_v);
  assign vq_x   = XW'(vquo);

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && ctrl_i.close) begin
      f_sum_q <= sum_d;
      f_sq_q  <= sq_d;
      f_max_q <= max_d;
      f_min_q <= min_d;
      f_k_q   <= k_i;
    end
    if (st_q == S_PREP) begin
      mag_q   <= f_sum_q[SW-1] ? SW'(-f_sum_q) : SW'(f_sum_q);
      den_q   <= DW'(f_k_q) * DW'(f_k_q - 1'b1);
      prod_q  <= '0;
      mcand_q <= NW'(f_sq_q);
      mk_q    <= f_k_q;
      mcnt_q  <= MCW'(CW);
    end
    if (st_q == S_MUL) begin
      magsq_q <= NW'(mag_q) * NW'(mag_q);
      if (mk_q[0]) prod_q <= prod_q + mcand_q;
      mcand_q <= {mcand_q[NW-2:0], 1'b0};
      mk_q    <= mk_q >> 1;
      mcnt_q  <= mcnt_q - 1'b1;
    end
    if (st_q == S_SUB) begin
      num_q <= prod_q - magsq_q;
    end
    if (st_q == S_WAIT && vdone && mdone) begin
      mean_q <= OutBits'(mean_t);
      var_q  <= (|vq_x[XW-1:VarBits]) ? {VarBits{1'b1}} : VarBits'(vq_x);
    end
  end

  was_div #(.NW(NW), .DW(DW)) u_vdiv (
    .clk_i, .rst_ni, .start_i(div_go), .num_i(num_q), .den_i(den_q),
    .done_o(vdone), .quo_o(vquo), .rem_o(vrem)
  );

  was_div #(.NW(SW), .DW(CW)) u_mdiv (
    .clk_i, .rst_ni, .start_i(div_go), .num_i(mag_q), .den_i(f_k_q),
    .done_o(mdone), .quo_o(mquo), .rem_o(mrem)
  );

  assign stat_o.busy = (st_q != S_IDLE) || (vrem != vrem);
  assign stat_o.done = (st_q == S_DONE);
  assign mean_o = mean_q;
  assign var_o  = var_q;
  assign max_o  = OutBits'(f_max_q);
  assign min_o  = OutBits'(f_min_q);

endmodule

### rtl/windowed_axis_statistics.sv
// ----------------------------------------------------------------------------
// windowed_axis_statistics
// Per-axis mean, sample variance, max and min over fixed sample windows.
// ----------------------------------------------------------------------------
// Three axis lanes accumulate one active sample beat per cycle. The beat that
// fills the window hands the totals to each lane's finishing sequencer and
// the input stalls until it ends. Its run is set by the bit-serial k*sumsq
// product and the one-bit-per-cycle variance divider. A beat with active
// low restarts the window and yields nothing. Window lengths below 2 act
// as 2, above MAX_WINDOW as MAX_WINDOW. No reset sweep is needed.
module windowed_axis_statistics import was_pkg::*; #(
  parameter int unsigned MAX_WINDOW  = DefMaxWindow,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LenBits-1:0]     cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   active_i,
  input  logic [SAMPLE_BITS-1:0] sample_x_i,
  input  logic [SAMPLE_BITS-1:0] sample_y_i,
  input  logic [SAMPLE_BITS-1:0] sample_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OutBits-1:0]     mean_x_o,
  output logic [OutBits-1:0]     mean_y_o,
  output logic [OutBits-1:0]     mean_z_o,
  output logic [VarBits-1:0]     var_x_o,
  output logic [VarBits-1:0]     var_y_o,
  output logic [VarBits-1:0]     var_z_o,
  output logic [OutBits-1:0]     max_x_o,
  output logic [OutBits-1:0]     max_y_o,
  output logic [OutBits-1:0]     max_z_o,
  output logic [OutBits-1:0]     min_x_o,
  output logic [OutBits-1:0]     min_y_o,
  output logic [OutBits-1:0]     min_z_o
);

  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned EW = (CW > LenBits) ? CW : LenBits;

  logic [LenBits-1:0] wlen_q;
  logic [CW-1:0]      cnt_q;
  logic [EW-1:0]      wl_x, n_eff, cnt_nx;
  logic               fin_q, out_valid_q, beat, close, take;
  was_ctrl_t          ctrl;
  was_stat_t          stat [3];
  logic [SAMPLE_BITS-1:0] smp [3];
  logic [OutBits-1:0] mean_l [3], max_l [3], min_l [3];
  logic [VarBits-1:0] var_l [3];
  logic [OutBits-1:0] mean_q [3], max_q [3], min_q [3];
  logic [VarBits-1:0] var_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WinReset;
    end else if (cfg_we_i) begin
      wlen_q <= cfg_wdata_i;
    end
  end

  assign wl_x   = EW'(wlen_q);
  assign n_eff  = (wl_x < EW'(2)) ? EW'(2) :
                  (wl_x > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : wl_x;
  assign cnt_nx = EW'(cnt_q) + EW'(1);

  assign in_ready_o = !fin_q;
  assign beat       = in_valid_i && in_ready_o;
  assign close      = beat && active_i && (cnt_nx >= n_eff);
  assign take       = stat[0].done && stat[1].done && stat[2].done &&
                      (!out_valid_q || out_ready_i);

  assign ctrl.acc   = beat && active_i;
  assign ctrl.clr   = beat && !active_i;
  assign ctrl.close = close;
  assign ctrl.take  = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.clr || close) begin
        cnt_q <= '0;
      end else if (ctrl.acc) begin
        cnt_q <= CW'(cnt_nx);
      end
      if (close) begin
        fin_q <= 1'b1;
      end else if (take) begin
        fin_q <= 1'b0;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign smp[0] = sample_x_i;
  assign smp[1] = sample_y_i;
  assign smp[2] = sample_z_i;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    was_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CW(CW)) u_lane (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .k_i(CW'(cnt_nx)), .sample_i(smp[a]),
      .stat_o(stat[a]), .mean_o(mean_l[a]), .var_o(var_l[a]),
      .max_o(max_l[a]), .min_o(min_l[a])
    );

    always_ff @(posedge clk_i) begin
      if (take) begin
        mean_q[a] <= mean_l[a];
        var_q[a]  <= var_l[a];
        max_q[a]  <= max_l[a];
        min_q[a]  <= min_l[a];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_x_o = mean_q[0];
  assign mean_y_o = mean_q[1];
  assign mean_z_o = mean_q[2];
  assign var_x_o  = var_q[0];
  assign var_y_o  = var_q[1];
  assign var_z_o  = var_q[2];
  assign max_x_o  = max_q[0];
  assign max_y_o  = max_q[1];
  assign max_z_o  = max_q[2];
  assign min_x_o  = min_q[0];
  assign min_y_o  = min_q[1];
  assign min_z_o  = min_q[2];

  // lanes run in lockstep
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat[0].done == stat[1].done) && (stat[1].done == stat[2].done))
    else $error("lanes out of step");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(cnt_q) < EW'(MAX_WINDOW))
    else $error("window count overflow");

  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close |=> fin_q && stat[0].busy)
    else $error("window close not picked up");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q && !fin_q)
    else $error("result not delivered");

endmodule
